### src/rdm_pkg.sv
// Shared types and command codes for the regex dot-star matcher.
`timescale 1ns / 1ps

package rdm_pkg;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 5;
  localparam int LENGTH_W = 6;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TEXT  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              repeat_flag;
    logic              any_flag;
    logic [CHAR_W-1:0] ch;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               load;
    logic               step;
    logic               restart;
    logic               query;
    logic [INDEX_W-1:0] entry_index;
    entry_t             entry;
    logic [CHAR_W-1:0]  text_char;
  } cell_ctrl_t;

  // Handed from each cell to its right-hand neighbor.
  typedef struct packed {
    logic scan;  // closure carry over the current active set
    logic fin;   // closure carry over the updated set, for the answer
    logic adv;   // a hit on a plain entry moves to the next position
  } cell_link_t;

endpackage

### src/regex_dot_star_matcher_unit.sv
// Top level of the regex dot-star matcher: a chain of pattern cells.
`timescale 1ns / 1ps
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  -----------------------------------------
//  in       request    in_valid / in_stall   cmd, entry_index, entry_char, entry_any,
//                                            entry_repeat, text_char, text_last
//  out      result     out_valid / out_stall matched
//  cfg      write      cfg_wr_en             cfg_wr_data (pattern_length)
//
//  One request per cycle, every command, while in_stall is low. A result is registered
//  into the result buffer when the final text character or the empty-text query is taken.
//  The clock period is set by the closure carry rippling once across the cell row
//  for the current set and once more for the updated set feeding the answer.
//  Reset clears the active set, length register and result buffer, not pattern entries.
//  Results sit in a two-entry buffer; in_stall rises only when both are held.

module regex_dot_star_matcher_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [4:0] entry_index,
  input  logic [7:0] entry_char,
  input  logic       entry_any,
  input  logic       entry_repeat,
  input  logic [7:0] text_char,
  input  logic       text_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);
  import rdm_pkg::*;

  // Wide enough for both the register and PATTERN_MAX itself.
  localparam int LEN_W = ($clog2(PATTERN_MAX + 1) > LENGTH_W) ?
                         $clog2(PATTERN_MAX + 1) : LENGTH_W;

  logic [LENGTH_W-1:0] pattern_length;
  logic [LEN_W-1:0]    used_len;
  logic                in_accept;
  logic                result_push;
  logic                result_now;
  cell_ctrl_t          ctrl;
  cell_link_t          link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] fin_vec;
  logic [PATTERN_MAX:0] at_end;
  logic [PATTERN_MAX-1:0] in_use;
  logic                end_active_next;

  // Hold the length register; writes must come only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  // Saturate the length at the number of cells.
  always_comb begin
    if (LEN_W'(pattern_length) > LEN_W'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = LEN_W'(pattern_length);
    end
  end

  assign in_accept = in_valid & ~in_stall;

  // Decode the accepted request into the broadcast control word.
  always_comb begin
    ctrl.load        = 1'b0;
    ctrl.step        = 1'b0;
    ctrl.query       = 1'b0;
    ctrl.entry_index = entry_index;
    ctrl.entry       = '{repeat_flag: entry_repeat, any_flag: entry_any, ch: entry_char};
    ctrl.text_char   = text_char;
    if (in_accept) begin
      unique case (cmd)
        CMD_LOAD:  ctrl.load  = 1'b1;
        CMD_TEXT:  ctrl.step  = 1'b1;
        CMD_QUERY: ctrl.query = 1'b1;
        default:   ctrl.load  = 1'b0;
      endcase
    end
    // Restart the set after answering: final character or empty-text query.
    ctrl.restart = (ctrl.step & text_last) | ctrl.query;
  end

  assign result_push = ctrl.restart;

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    assign in_use[i] = (LEN_W'(i) < used_len);

    rdm_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_use     (in_use[i]),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .fin_closed (fin_vec[i])
    );
  end

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_end
    assign at_end[i] = (LEN_W'(i) == used_len);
  end

  // The end-of-pattern position has no entry: it only collects advances.
  // Its stored flag never reaches an answer, so it is not kept.
  assign end_active_next = link[PATTERN_MAX].adv;
  assign fin_vec[PATTERN_MAX] = (ctrl.query ? 1'b0 : end_active_next) |
                                link[PATTERN_MAX].fin;

  // Pick the closed flag at the pattern length.
  assign result_now = |(fin_vec & at_end);

  rdm_out_skid u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (result_push),
    .push_matched (result_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched      (matched),
    .full         (in_stall)
  );

endmodule

### src/rdm_cell.sv
// One pattern position: its entry, its active flag and its closure links.
`timescale 1ns / 1ps

module rdm_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  rdm_pkg::cell_ctrl_t ctrl,
  input  logic               in_use,
  input  rdm_pkg::cell_link_t link_in,
  output rdm_pkg::cell_link_t link_out,
  output logic               fin_closed
);
  import rdm_pkg::*;

  localparam logic START = (IDX == 0);

  entry_t entry;
  logic   active;
  logic   active_next;
  logic   closed;
  logic   hit;
  logic   take;
  logic   fin_raw;
  logic   wr_hit;

  assign wr_hit = ctrl.load && ({4'b0, ctrl.entry_index} == 9'(IDX));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      entry <= ctrl.entry;
    end
  end

  always_comb begin
    closed      = active | link_in.scan;
    hit         = entry.any_flag | (entry.ch == ctrl.text_char);
    take        = closed & in_use & hit;
    active_next = (take & entry.repeat_flag) | link_in.adv;
    fin_raw     = ctrl.query ? START : active_next;
    fin_closed  = fin_raw | link_in.fin;
    link_out.scan = closed & entry.repeat_flag & in_use;
    link_out.fin  = fin_closed & entry.repeat_flag & in_use;
    link_out.adv  = take & ~entry.repeat_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= START;
    end else if (ctrl.restart) begin
      active <= START;
    end else if (ctrl.step) begin
      active <= active_next;
    end
  end

endmodule

### src/rdm_out_skid.sv
// Two-entry result buffer between the cell chain and the output channel.
`timescale 1ns / 1ps

module rdm_out_skid (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_matched,
  output logic out_valid,
  input  logic out_stall,
  output logic matched,
  output logic full
);
  import rdm_pkg::*;

  logic skid_valid;
  logic skid_matched;
  logic out_fire;

  assign out_fire = out_valid & ~out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        matched <= skid_matched;
      end
    end else if (push) begin
      if (out_valid && !out_fire) begin
        skid_matched <= push_matched;
      end else begin
        matched <= push_matched;
      end
    end
  end

endmodule

### src/rdm_checker.sv
// Port-level assertions for the regex dot-star matcher, bound to the top level.
`timescale 1ns / 1ps

module rdm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic       matched
);
  import rdm_pkg::*;

  logic in_accept;
  assign in_accept = in_valid & ~in_stall;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched))
    else $error("stalled result changed");

  // Input backs up only behind a waiting result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // A load into an empty output gives no result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_accept && cmd == CMD_LOAD |=> !out_valid)
    else $error("load produced a result");

  // A query into an empty output answers on the next cycle.
  a_query_answers: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_accept && cmd == CMD_QUERY |=> out_valid)
    else $error("query gave no result");

  // Drop everything on reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left output state");

endmodule

bind regex_dot_star_matcher_unit rdm_checker u_rdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .matched   (matched)
);

### test/match_checker.sv
// Checker for the regex dot-star matcher: predicts each answer and compares it.
`timescale 1ns / 1ps

module match_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [4:0] entry_index,
  input  logic [7:0] entry_char,
  input  logic       entry_any,
  input  logic       entry_repeat,
  input  logic [7:0] text_char,
  input  logic       text_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       matched,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  output int         mismatch_count,
  output int         open_results
);

  import rdm_pkg::*;

  localparam int SLOTS = 32;

  entry_t          pattern_mem [SLOTS];
  logic [SLOTS:0]  live_set;
  logic [SLOTS:0]  closed_set;
  logic [SLOTS:0]  next_set;
  logic [5:0]      length_reg;
  int unsigned     span;
  bit              match_queue [$];
  bit              wanted;

  // Mark every position reachable by skipping repeat entries.
  function automatic logic [SLOTS:0] close_over_repeats(input logic [SLOTS:0] raw,
                                                        input int unsigned len);
    logic [SLOTS:0] c;
    c = raw;
    for (int i = 0; i < len; i++)
      if (c[i] && pattern_mem[i].repeat_flag) c[i+1] = 1'b1;
    return c;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Queue the answer for the current set, then restart at position zero.
  task automatic answer_and_restart();
    closed_set = close_over_repeats(live_set, span);
    match_queue.push_back(closed_set[span]);
    live_set = (SLOTS+1)'(1);
  endtask

  task automatic take_request();
    span = (length_reg > SLOTS) ? SLOTS : length_reg;
    case (cmd)
      CMD_LOAD: pattern_mem[entry_index] = {entry_repeat, entry_any, entry_char};
      CMD_QUERY: begin
        live_set = (SLOTS+1)'(1);
        answer_and_restart();
      end
      CMD_TEXT: begin
        closed_set = close_over_repeats(live_set, span);
        next_set = '0;
        for (int i = 0; i < span; i++) begin
          if (closed_set[i] &&
              (pattern_mem[i].any_flag || pattern_mem[i].ch == text_char)) begin
            if (pattern_mem[i].repeat_flag) next_set[i] = 1'b1;
            else next_set[i+1] = 1'b1;
          end
        end
        live_set = next_set;
        if (text_last) answer_and_restart();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      live_set = (SLOTS+1)'(1);
      length_reg = '0;
      match_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (match_queue.size() == 0) begin
          flag_mismatch($sformatf("result matched=%0b with no request waiting", matched));
        end else begin
          wanted = match_queue.pop_front();
          if (matched !== wanted)
            flag_mismatch($sformatf("matched=%0b, want %0b", matched, wanted));
        end
      end
      if (cfg_wr_en) length_reg = cfg_wr_data;
      if (in_valid && !in_stall) take_request();
    end
    open_results = match_queue.size();
  end

endmodule

### test/testbench.sv
// Top of the matcher testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;

  import rdm_pkg::*;

  // cmd 3 has no meaning; the block must drop it without an answer
  localparam logic [1:0] CMD_IGNORED   = 2'd3;
  localparam int         SLOTS         = 32;
  localparam int         RANDOM_ITEMS  = 1050;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 4;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic [1:0] cmd          = '0;
  logic [4:0] entry_index  = '0;
  logic [7:0] entry_char   = '0;
  logic       entry_any    = 1'b0;
  logic       entry_repeat = 1'b0;
  logic [7:0] text_char    = '0;
  logic       text_last    = 1'b0;
  logic       out_stall    = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic [5:0] cfg_wr_data  = '0;
  logic       in_stall;
  logic       out_valid;
  logic       matched;

  int mismatch_count;
  int open_results;

  // Idle rates of both sides, in percent per cycle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long output hold: the stimulus asks, the receiver counts it out.
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Requests the block acts on; dropped commands do not count.
  int counted_items = 0;

  // Stimulus-side copy of the pattern, used only to build matching text.
  entry_t     pattern_copy [SLOTS];
  int         pattern_len_used = 0;
  logic [7:0] text_buf [$];

  regex_dot_star_matcher_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_char   (entry_char),
    .entry_any    (entry_any),
    .entry_repeat (entry_repeat),
    .text_char    (text_char),
    .text_last    (text_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched      (matched),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  match_checker match_watch (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .entry_char     (entry_char),
    .entry_any      (entry_any),
    .entry_repeat   (entry_repeat),
    .text_char      (text_char),
    .text_last      (text_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .matched        (matched),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  always #4 clk = ~clk;

  // Receiver: serve a pending long hold first, else stall at the current rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Mostly a small alphabet so texts and patterns line up; the extremes
  // of the byte range and any other value now and then.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return "a" + 8'($urandom_range(2));
    if (roll < 86) return 8'h00;
    if (roll < 92) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic entry_t make_entry(input logic [7:0] c, input logic wild,
                                        input logic rep);
    entry_t e;
    e.ch          = c;
    e.any_flag    = wild;
    e.repeat_flag = rep;
    return e;
  endfunction

  function automatic entry_t random_entry();
    return make_entry(pick_char(), $urandom_range(3) == 0, $urandom_range(99) < 35);
  endfunction

  // Offer one request and hold it until taken. Idle cycles come before the
  // offer, so valid is never dropped and raised in the same step.
  task automatic send_req(input logic [1:0] c, input logic [4:0] idx, input entry_t e,
                          input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    entry_index  <= idx;
    entry_char   <= e.ch;
    entry_any    <= e.any_flag;
    entry_repeat <= e.repeat_flag;
    text_char    <= ch;
    text_last    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c != CMD_IGNORED) counted_items++;
  endtask

  // Unused fields of each request carry random bits.
  task automatic load_entry(input logic [4:0] idx, input entry_t e);
    send_req(CMD_LOAD, idx, e, 8'($urandom), 1'($urandom));
    pattern_copy[idx] = e;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    send_req(CMD_TEXT, 5'($urandom), entry_t'(10'($urandom)), ch, last);
  endtask

  task automatic ask_empty();
    send_req(CMD_QUERY, 5'($urandom), entry_t'(10'($urandom)), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    send_req(CMD_IGNORED, 5'($urandom), entry_t'(10'($urandom)), 8'($urandom),
             1'($urandom));
  endtask

  // Drop valid, wait for every answer, then let loads finish inside the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [5:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pattern_len_used = (v > SLOTS) ? SLOTS : v;
  endtask

  // Build a text the current pattern accepts; a mutation may break it.
  task automatic build_text(input bit mutate);
    int reps;
    int k;
    text_buf.delete();
    for (int i = 0; i < pattern_len_used; i++) begin
      reps = pattern_copy[i].repeat_flag ? $urandom_range(3) : 1;
      repeat (reps)
        text_buf.push_back(pattern_copy[i].any_flag ? pick_char() : pattern_copy[i].ch);
    end
    if (mutate) begin
      k = $urandom_range(text_buf.size());
      case ($urandom_range(2))
        0: if (k < text_buf.size()) text_buf[k] = pick_char();
        1: if (k < text_buf.size()) text_buf.delete(k);
        default: text_buf.insert(k, pick_char());
      endcase
    end
  endtask

  // Stream the text; now and then slip a load or a dropped command in between.
  task automatic send_text();
    if (text_buf.size() == 0) ask_empty();
    for (int k = 0; k < text_buf.size(); k++) begin
      if ($urandom_range(99) < 3) load_entry(5'($urandom), random_entry());
      else if ($urandom_range(99) < 2) send_noise();
      send_char(text_buf[k], k == text_buf.size() - 1);
    end
  endtask

  // One round: set a length, load every entry in use, then run texts until
  // the phase has sent its share. The first rounds force the length
  // extremes, saturation included.
  task automatic run_round(input int round_no, input int stop_at);
    int len_code;
    int roll;
    case (round_no)
      0: len_code = SLOTS;
      1: len_code = 63;
      2: len_code = 0;
      3: len_code = SLOTS + 1;
      default: begin
        roll = $urandom_range(99);
        if (roll < 70) len_code = $urandom_range(6);
        else if (roll < 90) len_code = $urandom_range(SLOTS, 7);
        else len_code = $urandom_range(63, SLOTS + 1);
      end
    endcase
    write_length(6'(len_code));
    for (int i = 0; i < pattern_len_used; i++) load_entry(5'(i), random_entry());
    if ($urandom_range(3) == 0) load_entry(5'($urandom), random_entry());
    repeat ($urandom_range(10, 4)) begin
      if (counted_items < stop_at) begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          build_text(roll >= 55);
          send_text();
        end else if (roll < 88) begin
          text_buf.delete();
          repeat ($urandom_range(6, 1)) text_buf.push_back(pick_char());
          send_text();
        end else if (roll < 93) begin
          ask_empty();
        end else if (roll < 97) begin
          // abandon a partial text with a query
          repeat ($urandom_range(3, 1)) send_char(pick_char(), 1'b0);
          ask_empty();
        end else begin
          send_noise();
        end
      end
    end
  endtask

  initial begin
    int phase_start;
    int round_no;
    round_no = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pattern, literal zero, wildcard, repeat skipped and
    // taken, query mid-text, a load mid-text and a dropped command.
    write_length(6'd0);
    ask_empty();
    send_char(8'h00, 1'b1);
    load_entry(5'd0, make_entry("a", 1'b0, 1'b0));
    load_entry(5'd1, make_entry("x", 1'b1, 1'b0));
    load_entry(5'd2, make_entry("b", 1'b0, 1'b1));
    load_entry(5'd3, make_entry(8'h00, 1'b0, 1'b0));
    load_entry(5'd31, make_entry(8'hFF, 1'b1, 1'b1));
    write_length(6'd4);
    send_char("a", 1'b0);
    send_char("z", 1'b0);
    send_char("b", 1'b0);
    send_char("b", 1'b0);
    send_char(8'h00, 1'b1);
    send_char("a", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char("a", 1'b0);
    ask_empty();
    send_char("b", 1'b1);
    send_noise();
    send_char("a", 1'b0);
    load_entry(5'd1, make_entry("q", 1'b0, 1'b0));
    send_char("q", 1'b0);
    send_char(8'h00, 1'b1);

    // Random: receiver idle heavy, then sender idle heavy, then full rate.
    for (int p = 0; p < 3; p++) begin
      phase_start = counted_items;
      case (p)
        0: begin send_idle_pct = 23; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 2) begin
        // Hold the output off while queries keep coming, so the result
        // buffer fills and the block must stall its input.
        hold_asked++;
        repeat (24) ask_empty();
      end
      while (counted_items - phase_start < RANDOM_ITEMS / 3) begin
        run_round(round_no, phase_start + RANDOM_ITEMS / 3);
        round_no++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
src/rdm_pkg.sv
src/rdm_cell.sv
src/rdm_out_skid.sv
src/regex_dot_star_matcher_unit.sv
src/rdm_checker.sv
test/match_checker.sv
test/testbench.sv
